// ----- rtl/status_frame_checker_core_defines.svh -----
// Assertion macros for the status frame checker RTL.
// No dependencies; included by status_frame_checker_core.sv.
`ifndef STATUS_FRAME_CHECKER_CORE_DEFINES_SVH
`define STATUS_FRAME_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SFC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/sfc_pkg.sv -----
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the
// status frame checker. No dependencies.
package sfc_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // frame byte offsets
   localparam logic [3:0] POS_HDR0  = 4'd0;
   localparam logic [3:0] POS_HDR1  = 4'd1;
   localparam logic [3:0] POS_TYPE  = 4'd2;
   localparam logic [3:0] POS_STATE = 4'd3;
   localparam logic [3:0] POS_ERROR = 4'd4;
   localparam logic [3:0] POS_CRCL  = 4'd5;
   localparam logic [3:0] POS_CRCH  = 4'd6;
   localparam logic [3:0] POS_TAIL0 = 4'd7;
   localparam logic [3:0] POS_TAIL1 = 4'd8;

   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_FRAMING = 2'd1,
      CAUSE_CRC     = 2'd2
   } cause_type;

   typedef enum logic [2:0] {
      REG_HEADER0 = 3'd0,
      REG_HEADER1 = 3'd1,
      REG_TYPE    = 3'd2,
      REG_TAIL0   = 3'd3,
      REG_TAIL1   = 3'd4
   } reg_index_type;

   // one byte of CRC-16/CCITT-FALSE, MSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/status_frame_checker_core.sv -----
// Status frame checker top level: input stage, frame tracking, CRC check,
// result register and CSR block. Uses sfc_pkg and the assertion macros.
//
// Usage:
//  - req channel: one received byte per transfer. req_tdata = rx_byte,
//    req_tuser = frame_start (1 forces this byte to be frame offset 0 and
//    drops any partial frame).
//  - Frames are 9 bytes: header0, header1, type, state, error, CRC low,
//    CRC high, tail0, tail1. Without frame_start the offset free-runs 0..8.
//  - rsp channel: one transfer per completed frame, after the tail1 byte.
//    rsp_tuser = {fail_cause, frame_ok}; rsp_tdata = {ctrl_error, ctrl_state},
//    both zero on a failed frame. Framing mismatch outranks CRC mismatch.
//  - Timing: a byte is registered in the input register on accept and is
//    processed from there; a frame's result is held in the result register.
//  - Throughput: one byte per cycle but for tail1 stalls; the CRC byte update
//    is a single 8-step unrolled XOR network between input and state registers.
//  - Stalls: bytes that close no frame keep flowing while rsp is stalled;
//    a tail1 byte waits in the input register until the result register
//    frees, which then holds req_tready low.
//  - Reset (synchronous): pipeline empty, offset 0, CRC 0xFFFF, all CSRs 0.
//  - CSRs (APB, 4-byte spacing): header0, header1, type, tail0, tail1.
//    Write only while no frame is in progress.
`include "status_frame_checker_core_defines.svh"

module status_frame_checker_core
   import sfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] rx_byte
   input  logic        req_tuser,     // [0] frame_start
   // frame result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [7:0] ctrl_state, [15:8] ctrl_error
   output logic [2:0]  rsp_tuser,     // [0] frame_ok, [2:1] fail_cause
   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------- CSRs ----------------
   logic [7:0] hdr0_ff, hdr0_in;
   logic [7:0] hdr1_ff, hdr1_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] tail0_ff, tail0_in;
   logic [7:0] tail1_ff, tail1_in;
   logic       csr_wr;
   reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      hdr0_in  = hdr0_ff;
      hdr1_in  = hdr1_ff;
      type_in  = type_ff;
      tail0_in = tail0_ff;
      tail1_in = tail1_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_HEADER0: hdr0_in  = csr_pwdata[7:0];
            REG_HEADER1: hdr1_in  = csr_pwdata[7:0];
            REG_TYPE:    type_in  = csr_pwdata[7:0];
            REG_TAIL0:   tail0_in = csr_pwdata[7:0];
            REG_TAIL1:   tail1_in = csr_pwdata[7:0];
            default:     ;  // unmapped, ignored
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_HEADER0: csr_prdata = {24'h0, hdr0_ff};
         REG_HEADER1: csr_prdata = {24'h0, hdr1_ff};
         REG_TYPE:    csr_prdata = {24'h0, type_ff};
         REG_TAIL0:   csr_prdata = {24'h0, tail0_ff};
         REG_TAIL1:   csr_prdata = {24'h0, tail1_ff};
         default:     csr_prdata = 32'h0;
      endcase
   end

   // ---------------- input stage ----------------
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_start_ff;
   logic       req_xfer;
   logic       s1_fire;
   logic       s1_last;
   logic       out_free;

   assign req_xfer    = req_tvalid & req_tready;
   assign out_free    = ~rsp_tvalid | rsp_tready;
   // a byte that closes a frame needs room in the result register
   assign s1_fire     = s1_valid_ff & (~s1_last | out_free);
   assign req_tready  = ~s1_valid_ff | s1_fire;
   assign s1_valid_in = req_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   // ---------------- frame tracking ----------------
   logic [3:0]  pos_ff, pos_in, pos_eff;
   logic [15:0] crc_ff, crc_in, crc_base;
   logic        good_ff, good_in, good_base;
   logic [15:0] rcrc_ff, rcrc_in, rcrc_base;
   logic [7:0]  state_ff, state_in;
   logic [7:0]  error_ff, error_in;
   logic [15:0] crc_next;
   cause_type   cause;

   assign pos_eff   = (s1_start_ff || pos_ff > POS_TAIL1) ? POS_HDR0 : pos_ff;
   assign s1_last   = (pos_eff == POS_TAIL1);
   assign crc_base  = (pos_eff == POS_HDR0) ? CRC_INIT : crc_ff;
   assign good_base = (pos_eff == POS_HDR0) ? 1'b1 : good_ff;
   assign rcrc_base = (pos_eff == POS_HDR0) ? 16'h0 : rcrc_ff;
   assign crc_next  = crc16_byte(crc_base, s1_byte_ff);

   always_comb begin
      crc_in   = crc_base;
      good_in  = good_base;
      rcrc_in  = rcrc_base;
      state_in = state_ff;
      error_in = error_ff;
      case (pos_eff)
         POS_HDR0:  good_in = good_base & (s1_byte_ff == hdr0_ff);
         POS_HDR1:  good_in = good_base & (s1_byte_ff == hdr1_ff);
         POS_TYPE: begin
            good_in = good_base & (s1_byte_ff == type_ff);
            crc_in  = crc_next;
         end
         POS_STATE: begin
            state_in = s1_byte_ff;
            crc_in   = crc_next;
         end
         POS_ERROR: begin
            error_in = s1_byte_ff;
            crc_in   = crc_next;
         end
         POS_CRCL:  rcrc_in = {rcrc_base[15:8], s1_byte_ff};
         POS_CRCH:  rcrc_in = {s1_byte_ff, rcrc_base[7:0]};
         POS_TAIL0: good_in = good_base & (s1_byte_ff == tail0_ff);
         POS_TAIL1: good_in = good_base & (s1_byte_ff == tail1_ff);
         default:   ;  // offset is always folded into 0..8
      endcase
      pos_in = s1_last ? POS_HDR0 : pos_eff + 4'd1;
      // the frame closes: restart for the next one
      if (s1_last) begin
         crc_in  = CRC_INIT;
         good_in = 1'b1;
      end
   end

   // verdict for the closing byte (good_in/crc_in before restart above)
   logic good_final;
   assign good_final = good_base & (s1_byte_ff == tail1_ff);

   always_comb begin
      if (!good_final) begin
         cause = CAUSE_FRAMING;
      end else if (rcrc_base != crc_ff) begin
         cause = CAUSE_CRC;
      end else begin
         cause = CAUSE_NONE;
      end
   end

   // ---------------- result register ----------------
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_ok_ff;
   cause_type  rsp_cause_ff;
   logic [7:0] rsp_state_ff;
   logic [7:0] rsp_error_ff;
   logic       rsp_load;

   assign rsp_load     = s1_fire & s1_last;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_cause_ff, rsp_ok_ff};
   assign rsp_tdata  = {rsp_error_ff, rsp_state_ff};

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr0_ff      <= 8'h0;
         hdr1_ff      <= 8'h0;
         type_ff      <= 8'h0;
         tail0_ff     <= 8'h0;
         tail1_ff     <= 8'h0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= POS_HDR0;
         crc_ff       <= CRC_INIT;
         good_ff      <= 1'b1;
      end else begin
         hdr0_ff      <= hdr0_in;
         hdr1_ff      <= hdr1_in;
         type_ff      <= type_in;
         tail0_ff     <= tail0_in;
         tail1_ff     <= tail1_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            pos_ff  <= pos_in;
            crc_ff  <= crc_in;
            good_ff <= good_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff  <= req_tdata;
         s1_start_ff <= req_tuser;
      end
      if (s1_fire) begin
         rcrc_ff  <= rcrc_in;
         state_ff <= state_in;
         error_ff <= error_in;
      end
      if (rsp_load) begin
         rsp_ok_ff    <= (cause == CAUSE_NONE);
         rsp_cause_ff <= cause;
         rsp_state_ff <= (cause == CAUSE_NONE) ? state_ff : 8'h0;
         rsp_error_ff <= (cause == CAUSE_NONE) ? error_ff : 8'h0;
      end
   end

   // ---------------- assertions ----------------
   logic frame_restarted;   // tracker back at a clean frame start
   logic rsp_ok_agrees;     // frame_ok set exactly when there is no cause
   logic rsp_fail_clean;    // failed frame carries zero state/error
   assign frame_restarted = (pos_ff == POS_HDR0) && good_ff && (crc_ff == CRC_INIT);
   assign rsp_ok_agrees   = (rsp_ok_ff == (rsp_cause_ff == CAUSE_NONE));
   assign rsp_fail_clean  = rsp_ok_ff || ((rsp_state_ff == 8'h0) && (rsp_error_ff == 8'h0));

   `SFC_ASSERT_NOW(a_pos_range, clock, reset, 1'b1, pos_ff <= POS_TAIL1, "offset out of range")
   `SFC_ASSERT_NEXT(a_pos_wrap, clock, reset, rsp_load, frame_restarted, "frame not restarted")
   `SFC_ASSERT_NOW(a_ok_cause, clock, reset, rsp_valid_ff, rsp_ok_agrees, "frame_ok vs cause")
   `SFC_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid_ff, rsp_fail_clean, "fail with payload")

endmodule

// ----- tb/tb_status_frame_checker_core.sv -----
// Self-checking testbench for status_frame_checker_core: byte stream in,
// one checked result per 9-byte frame out, CSR writes over APB between phases.
// Depends on sfc_pkg (types, CRC constants, offsets) and the RTL only.
`timescale 1ns / 1ps

module tb_status_frame_checker_core;
   import sfc_pkg::*;

   localparam int NUM_REGS        = 5;      // mapped CSRs, index 5..7 is a hole
   localparam int ITEMS_PER_PHASE = 200;
   localparam int NUM_PHASES      = 6;
   localparam int PRESSURE_PHASE  = 4;
   localparam int HOLD_CYCLES     = 400;    // long rsp back-pressure
   localparam int SETTLE_CYCLES   = 8;      // margin past the tail1-to-result path
   localparam int WATCHDOG_NS     = 600000; // far above a slow run

   typedef struct packed {
      logic       ok;
      cause_type  cause;
      logic [7:0] state;
      logic [7:0] error;
   } frame_result_type;

   typedef struct {
      logic [7:0]       data;
      logic             start;
      bit               fixed;   // expectation typed in, not predicted
      frame_result_type want;
   } stim_row_type;

   typedef logic [7:0] frame_bytes_type [9];

   typedef enum {FLAW_NONE, FLAW_FRAMING, FLAW_CRC, FLAW_CUT} frame_flaw_type;

   // ---------------------------------------------------------------- DUT
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        req_tuser;    // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [7:0] ctrl_state, [15:8] ctrl_error
   logic [2:0]  rsp_tuser;    // [0] frame_ok, [2:1] fail_cause
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   status_frame_checker_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------- tb state
   // frame predictor: CSR shadow plus its own copy of the frame tracker
   logic [7:0]  frame_cfg [NUM_REGS] = '{default: 8'h00};
   logic [3:0]  fp_pos        = POS_HDR0;
   logic [15:0] fp_crc        = CRC_INIT;
   logic        fp_framing_ok = 1'b1;
   logic [15:0] fp_rx_crc     = 16'h0000;
   logic [7:0]  fp_state      = 8'h00;
   logic [7:0]  fp_error      = 8'h00;

   frame_result_type pending_results [$];   // predicted, oldest first
   stim_row_type     directed_rows [$];

   int gap_pct      = 0;   // sender idle chance per transfer, percent
   int stall_pct    = 0;   // receiver stall chance per cycle, percent
   int hold_request = 0;   // handed to the rsp process, which counts it down
   int mismatches   = 0;
   int bytes_sent   = 0;
   int csr_writes   = 0;
   int frames_seen  = 0;
   int frames_ok    = 0;
   int frames_framing = 0;
   int frames_crc   = 0;

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case a handshake hangs
   initial begin : run_watchdog
      #(WATCHDOG_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------- predictor
   // CRC-16/CCITT-FALSE, one byte, MSB first: feedback bit per input bit
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[15] ^ b[i];
         crc = {crc[14:0], 1'b0};
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   // CRC over type, state, error as the block sees them
   function automatic logic [15:0] crc_of_body(input logic [7:0] t, input logic [7:0] s,
                                               input logic [7:0] e);
      return crc_step(crc_step(crc_step(CRC_INIT, t), s), e);
   endfunction

   // Advance the frame tracker by one accepted byte. Returns 1 when the byte
   // closes a frame; res then holds the result the block must give.
   function automatic bit predict_byte(input logic [7:0] b, input logic start,
                                       output frame_result_type res);
      logic [3:0] offset;
      offset = (start || fp_pos > POS_TAIL1) ? POS_HDR0 : fp_pos;
      res = '0;
      // frame_start or wrap: fresh CRC and framing verdict
      if (offset == POS_HDR0) begin
         fp_crc        = CRC_INIT;
         fp_framing_ok = 1'b1;
         fp_rx_crc     = 16'h0000;
      end
      case (offset)
         POS_HDR0: begin
            if (b != frame_cfg[REG_HEADER0]) fp_framing_ok = 1'b0;
         end
         POS_HDR1: begin
            if (b != frame_cfg[REG_HEADER1]) fp_framing_ok = 1'b0;
         end
         POS_TYPE: begin
            if (b != frame_cfg[REG_TYPE]) fp_framing_ok = 1'b0;
            fp_crc = crc_step(fp_crc, b);
         end
         POS_STATE: begin
            fp_state = b;
            fp_crc   = crc_step(fp_crc, b);
         end
         POS_ERROR: begin
            fp_error = b;
            fp_crc   = crc_step(fp_crc, b);
         end
         POS_CRCL: begin
            fp_rx_crc[7:0] = b;    // CRC field is little-endian
         end
         POS_CRCH: begin
            fp_rx_crc[15:8] = b;
         end
         POS_TAIL0: begin
            if (b != frame_cfg[REG_TAIL0]) fp_framing_ok = 1'b0;
         end
         default: begin
            if (b != frame_cfg[REG_TAIL1]) fp_framing_ok = 1'b0;
         end
      endcase
      if (offset != POS_TAIL1) begin
         fp_pos = offset + 4'd1;
         return 1'b0;
      end
      // framing outranks CRC; a failed frame reports zero state/error
      if (!fp_framing_ok) begin
         res.cause = CAUSE_FRAMING;
      end else if (fp_rx_crc != fp_crc) begin
         res.cause = CAUSE_CRC;
      end else begin
         res.ok    = 1'b1;
         res.cause = CAUSE_NONE;
         res.state = fp_state;
         res.error = fp_error;
      end
      fp_pos        = POS_HDR0;
      fp_crc        = CRC_INIT;
      fp_framing_ok = 1'b1;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------- reporting
   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("frame %0d %s: got 0x%0h, expected 0x%0h",
                                   frames_seen, name, got, want));
      end
   endtask

   // ------------------------------------------------------------- APB
   // setup, access, then idle, so back-to-back writes never
   // lower and raise psel in the same step
   task automatic csr_write(input int idx, input logic [7:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(idx << 2);
      csr_pwdata  <= {24'($urandom), val};   // upper bits are don't-care
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);                      // write lands here, pready high
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx < NUM_REGS) frame_cfg[idx] = val;   // holes are ignored
      csr_writes++;
      @(posedge clock);
   endtask

   // ------------------------------------------------------ req side
   // Offer one byte, wait for the transfer, then run the predictor on it.
   // tvalid is only lowered when a gap is taken, never dropped and re-raised
   // within the same step.
   task automatic send_byte(input logic [7:0] b, input logic start, input bit fixed,
                            input frame_result_type want);
      frame_result_type next_result;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (predict_byte(b, start, next_result)) begin
         pending_results.push_back(fixed ? want : next_result);
      end
   endtask

   // directed table: typed expectation goes on the closing tail1 row only
   task automatic add_frame_rows(input frame_bytes_type fb, input logic start,
                                 input bit fixed, input frame_result_type want);
      stim_row_type row;
      for (int k = 0; k < 9; k++) begin
         row.data  = fb[k];
         row.start = (k == 0) ? start : 1'b0;
         row.fixed = (k == 8) ? fixed : 1'b0;
         row.want  = want;
         directed_rows.push_back(row);
      end
   endtask

   // One frame built from the current CSR values with random state/error.
   // Flaws: a wrong framing byte (sometimes a wrong CRC too, to hit the
   // priority rule), a wrong CRC byte, or a frame cut short.
   task automatic send_frame(input frame_flaw_type flaw);
      frame_bytes_type fb;
      logic [15:0]     crc;
      int              n;
      int              k;
      logic            start;
      fb[POS_HDR0]  = frame_cfg[REG_HEADER0];
      fb[POS_HDR1]  = frame_cfg[REG_HEADER1];
      fb[POS_TYPE]  = frame_cfg[REG_TYPE];
      fb[POS_STATE] = 8'($urandom);
      fb[POS_ERROR] = 8'($urandom);
      crc = crc_of_body(fb[POS_TYPE], fb[POS_STATE], fb[POS_ERROR]);
      fb[POS_CRCL]  = crc[7:0];
      fb[POS_CRCH]  = crc[15:8];
      fb[POS_TAIL0] = frame_cfg[REG_TAIL0];
      fb[POS_TAIL1] = frame_cfg[REG_TAIL1];
      n = 9;
      case (flaw)
         FLAW_FRAMING: begin
            // pick one of header0, header1, type, tail0, tail1
            k = $urandom_range(4);
            if (k > POS_TYPE) k = k + POS_TAIL0 - POS_STATE;
            fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
            if ($urandom_range(1)) fb[POS_CRCH] = ~fb[POS_CRCH];
         end
         FLAW_CRC: begin
            k = $urandom_range(POS_CRCL, POS_CRCH);
            fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
         end
         FLAW_CUT: begin
            n = $urandom_range(1, 8);
         end
         default: begin
         end
      endcase
      for (int i = 0; i < n; i++) begin
         // mid-frame: resync with frame_start most of the time; aligned: either
         if (i != 0) start = 1'b0;
         else if (fp_pos != POS_HDR0) start = ($urandom_range(9) != 0);
         else start = 1'($urandom_range(1));
         send_byte(fb[i], start, 1'b0, '0);
      end
   endtask

   // random traffic; stops only on a frame boundary so CSR writes that
   // follow never land inside a frame
   task automatic run_random(input int budget);
      int first;
      int pick;
      int n;
      first = bytes_sent;
      while (bytes_sent - first < budget || fp_pos != POS_HDR0) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_frame(FLAW_NONE);
         end else if (pick < 78) begin
            send_frame(FLAW_FRAMING);
         end else if (pick < 86) begin
            send_frame(FLAW_CRC);
         end else if (pick < 93) begin
            send_frame(FLAW_CUT);
         end else begin
            // line noise with stray frame_start marks
            n = $urandom_range(1, 5);
            repeat (n) send_byte(8'($urandom), ($urandom_range(9) < 3), 1'b0, '0);
         end
      end
   endtask

   // stop offering, let every predicted result arrive, then let the
   // pipeline settle before any CSR write
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------ rsp side
   // Checks every result transfer against the oldest prediction and drives
   // rsp_tready: random stalls, or a counted hold when one is requested.
   initial begin : result_sink
      int               hold_left;
      frame_result_type want;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            frames_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("frame %0d: result with no frame pending",
                                         frames_seen));
            end else begin
               want = pending_results.pop_front();
               check_field("frame_ok",   8'(rsp_tuser[0]),   8'(want.ok));
               check_field("fail_cause", 8'(rsp_tuser[2:1]), 8'(want.cause));
               check_field("ctrl_state", rsp_tdata[7:0],     want.state);
               check_field("ctrl_error", rsp_tdata[15:8],    want.error);
               case (want.cause)
                  CAUSE_NONE:    frames_ok++;
                  CAUSE_FRAMING: frames_framing++;
                  default:       frames_crc++;
               endcase
            end
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ------------------------------------------------------ main flow
   initial begin : stimulus
      frame_bytes_type fb;
      logic [15:0]     crc;
      stim_row_type    row;
      logic [7:0]      val;
      int              gap_by_phase   [NUM_PHASES];
      int              stall_by_phase [NUM_PHASES];

      // every input known from time zero
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= 8'h00;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= 5'd0;
      csr_pwdata  <= 32'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, CSRs still at reset (all zero), no idling.
      // A stray byte opens a frame, then frame_start drops it; the new frame
      // has a bad header and a bad CRC, so framing wins and fields read zero.
      row = '{data: 8'hFF, start: 1'b0, fixed: 1'b0, want: '0};
      directed_rows.push_back(row);
      fb = '{8'hFF, 8'h00, 8'h00, 8'h5A, 8'hC3, 8'h00, 8'h00, 8'h00, 8'h00};
      add_frame_rows(fb, 1'b1, 1'b1,
                     '{ok: 1'b0, cause: CAUSE_FRAMING, state: 8'h00, error: 8'h00});
      // free-running back-to-back frame with a correct CRC: should pass
      crc = crc_of_body(8'h00, 8'hFF, 8'h00);
      fb = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, crc[7:0], crc[15:8], 8'h00, 8'h00};
      add_frame_rows(fb, 1'b0, 1'b0, '0);
      // frame_start on an aligned byte, CRC off by one bit: CRC cause
      crc = crc_of_body(8'h00, 8'h00, 8'hFF) ^ 16'h0001;
      fb = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, crc[7:0], crc[15:8], 8'h00, 8'h00};
      add_frame_rows(fb, 1'b1, 1'b1,
                     '{ok: 1'b0, cause: CAUSE_CRC, state: 8'h00, error: 8'h00});
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data, directed_rows[i].start,
                   directed_rows[i].fixed, directed_rows[i].want);
      end
      wait_idle();

      // random phases: all-zero CSRs, all-ones CSRs, then random values;
      // idling: none / sender 75% / receiver 75% / both 12% / hold / mixed
      gap_by_phase   = '{0, 75, 0, 12, 0, 25};
      stall_by_phase = '{0, 0, 75, 12, 0, 25};
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         for (int idx = 0; idx < NUM_REGS; idx++) begin
            case (phase)
               0:       val = 8'h00;
               1:       val = 8'hFF;
               default: val = 8'($urandom);
            endcase
            csr_write(idx, val);
         end
         // writes into the unmapped hole must change nothing
         if (phase == NUM_PHASES - 1) begin
            for (int idx = NUM_REGS; idx < 8; idx++) csr_write(idx, 8'($urandom));
         end
         gap_pct   = gap_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         // long rsp hold while bytes keep coming: the block must fill and
         // push back on req
         if (phase == PRESSURE_PHASE) hold_request = HOLD_CYCLES;
         run_random(ITEMS_PER_PHASE);
         wait_idle();
      end

      $display("Sent %0d bytes (directed + %0d random phases), %0d CSR writes.",
               bytes_sent, NUM_PHASES, csr_writes);
      $display("Checked %0d frame results: %0d ok, %0d framing fail, %0d CRC fail.",
               frames_seen, frames_ok, frames_framing, frames_crc);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- status_frame_checker_core.f -----
+incdir+rtl
rtl/sfc_pkg.sv
rtl/status_frame_checker_core.sv
tb/tb_status_frame_checker_core.sv
